/* hdl/kpqs_pkg.sv */
package kpqs_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int STACK_DEPTH  = 16;

   localparam int KEY_W   = 32;
   localparam int TAG_W   = 16;
   localparam int ADDR_W  = $clog2(MAX_ELEMENTS);
   localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
   localparam int IDX_W   = CNT_W + 1;
   localparam int SP_W    = $clog2(STACK_DEPTH + 1);
   localparam int SIDX_W  = $clog2(STACK_DEPTH);
   localparam int ELEM_W  = KEY_W + TAG_W;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [TAG_W-1:0]        tag_type;
   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [CNT_W-1:0]        cnt_type;
   typedef logic signed [IDX_W-1:0] idx_type;
   typedef logic [SP_W-1:0]         sp_type;

   typedef struct packed {
      key_type key;
      tag_type tag;
   } elem_type;

   typedef struct packed {
      addr_type lo;
      addr_type hi;
   } range_type;

endpackage

/* hdl/key_payload_quicksort_top.sv */
// Key/payload sorter: an in-place quicksort over an on-chip element store.
//
// Input channel (start/busy, req_*): a word is taken at a clock edge with
// start high and busy low. req_mode 0 loads req_key/req_tag at the next
// free slot; a load with req_last high closes the batch and sorts it. The
// next load after a sort starts a new batch. Loads past 1024 are dropped.
// req_mode 1 reads the element at sorted position req_read_index.
//
// Result channel (rsp_*): rsp_valid marks a word for exactly one cycle and
// the receiver must take it then. A read answers in the cycle right after
// it is taken (one registered store read); positions at or past the
// element count return zero key and tag. A closing load answers with
// rsp_sort_done high and the element count once the sort finishes.
//
// Loads can follow one another back to back; a read holds busy high until
// its answer is given. The sort runs on the single read port and single
// write port of the store, and busy stays high throughout.
// Reset: synchronous; empties the batch, the count and the range stack.
// The store itself is not cleared and needs no sweep.
module key_payload_quicksort_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_mode,
   input  logic signed [31:0]        req_key,
   input  logic [15:0]               req_tag,
   input  logic                      req_last,
   input  logic [kpqs_pkg::ADDR_W-1:0] req_read_index,
   output logic                      rsp_valid,
   output logic signed [31:0]        rsp_out_key,
   output logic [15:0]               rsp_out_tag,
   output logic [kpqs_pkg::CNT_W-1:0] rsp_count,
   output logic                      rsp_sort_done
);
   import kpqs_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_INIT   = 11'b000_0000_0010,
      S_RANGE  = 11'b000_0000_0100,
      S_PIVOT  = 11'b000_0000_1000,
      S_LOOP   = 11'b000_0001_0000,
      S_SCAN_I = 11'b000_0010_0000,
      S_SCAN_J = 11'b000_0100_0000,
      S_SWAP   = 11'b000_1000_0000,
      S_SPLIT  = 11'b001_0000_0000,
      S_DONE   = 11'b010_0000_0000,
      S_READ   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   logic      closed_ff, closed_in;
   sp_type    sp_ff, sp_in;
   idx_type   lo_ff, lo_in, hi_ff, hi_in, i_ff, i_in, j_ff, j_in;
   key_type   pivot_ff, pivot_in;
   elem_type  elem_i_ff, elem_i_in;
   logic      hit_ff, hit_in;
   range_type stack_ff [STACK_DEPTH];

   logic      wr_en;
   addr_type  wr_addr, rd_addr;
   elem_type  wr_data, rd_data;
   logic [ELEM_W-1:0] rd_raw;

   logic      push_en;
   range_type push_data;
   cnt_type   eff_count;
   idx_type   mid_sum, dlo, dhi;
   range_type top_range;

   kpqs_ram #(.DATA_W(ELEM_W), .DEPTH(MAX_ELEMENTS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_data   = elem_type'(rd_raw);
   assign eff_count = closed_ff ? '0 : count_ff;
   assign mid_sum   = lo_ff + hi_ff;
   assign top_range = stack_ff[SIDX_W'(sp_ff - 1'b1)];

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      closed_in = closed_ff;
      sp_in     = sp_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      pivot_in  = pivot_ff;
      elem_i_in = elem_i_ff;
      hit_in    = hit_ff;
      wr_en     = 1'b0;
      wr_addr   = i_ff[ADDR_W-1:0];
      wr_data   = rd_data;
      rd_addr   = i_ff[ADDR_W-1:0];
      push_en   = 1'b0;
      push_data = '0;
      dlo       = lo_ff;
      dhi       = hi_ff;

      case (state_ff)
         S_IDLE: begin
            rd_addr = req_read_index;
            if (start) begin
               if (!req_mode) begin
                  closed_in = 1'b0;
                  count_in  = eff_count;
                  if (eff_count < CNT_W'(MAX_ELEMENTS)) begin
                     wr_en    = 1'b1;
                     wr_addr  = eff_count[ADDR_W-1:0];
                     wr_data  = '{key: req_key, tag: req_tag};
                     count_in = eff_count + 1'b1;
                  end
                  if (req_last) begin
                     closed_in = 1'b1;
                     state_in  = S_INIT;
                  end
               end else begin
                  hit_in   = {1'b0, req_read_index} < count_ff;
                  state_in = S_READ;
               end
            end
         end
         S_INIT: begin
            lo_in    = '0;
            hi_in    = $signed({1'b0, count_ff}) - idx_type'(1);
            sp_in    = '0;
            state_in = S_RANGE;
         end
         S_RANGE: begin
            if (hi_ff > lo_ff) begin
               rd_addr  = mid_sum[ADDR_W:1];
               i_in     = lo_ff;
               j_in     = hi_ff;
               state_in = S_PIVOT;
            end else if (sp_ff == '0) begin
               state_in = S_DONE;
            end else begin
               sp_in = sp_ff - 1'b1;
               lo_in = $signed({2'b00, top_range.lo});
               hi_in = $signed({2'b00, top_range.hi});
            end
         end
         S_PIVOT: begin
            pivot_in = rd_data.key;
            state_in = S_LOOP;
         end
         S_LOOP: begin
            rd_addr  = i_ff[ADDR_W-1:0];
            state_in = (i_ff <= j_ff) ? S_SCAN_I : S_SPLIT;
         end
         S_SCAN_I: begin
            if (i_ff < hi_ff && rd_data.key < pivot_ff) begin
               i_in    = i_ff + idx_type'(1);
               rd_addr = i_in[ADDR_W-1:0];
            end else begin
               elem_i_in = rd_data;
               rd_addr   = j_ff[ADDR_W-1:0];
               state_in  = S_SCAN_J;
            end
         end
         S_SCAN_J: begin
            if (j_ff > lo_ff && pivot_ff < rd_data.key) begin
               j_in    = j_ff - idx_type'(1);
               rd_addr = j_in[ADDR_W-1:0];
            end else if (i_ff <= j_ff) begin
               // first half of the swap: element j lands at i
               wr_en    = 1'b1;
               wr_addr  = i_ff[ADDR_W-1:0];
               wr_data  = rd_data;
               state_in = S_SWAP;
            end else begin
               state_in = S_SPLIT;
            end
         end
         S_SWAP: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff[ADDR_W-1:0];
            wr_data  = elem_i_ff;
            i_in     = i_ff + idx_type'(1);
            j_in     = j_ff - idx_type'(1);
            state_in = S_LOOP;
         end
         S_SPLIT: begin
            // keep the smaller side, defer the larger one
            if ((j_ff - lo_ff) <= (hi_ff - i_ff)) begin
               dlo   = i_ff;
               dhi   = hi_ff;
               hi_in = j_ff;
            end else begin
               dlo   = lo_ff;
               dhi   = j_ff;
               lo_in = i_ff;
            end
            if (dhi > dlo && sp_ff < SP_W'(STACK_DEPTH)) begin
               push_en   = 1'b1;
               push_data = '{lo: dlo[ADDR_W-1:0], hi: dhi[ADDR_W-1:0]};
               sp_in     = sp_ff + 1'b1;
            end
            state_in = S_RANGE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         closed_ff <= 1'b0;
         sp_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         closed_ff <= closed_in;
         sp_ff     <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      pivot_ff  <= pivot_in;
      elem_i_ff <= elem_i_in;
      hit_ff    <= hit_in;
      if (push_en) begin
         stack_ff[SIDX_W'(sp_ff)] <= push_data;
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = (state_ff == S_READ) || (state_ff == S_DONE);
   assign rsp_sort_done = (state_ff == S_DONE);
   assign rsp_count     = count_ff;
   assign rsp_out_key   = (state_ff == S_READ && hit_ff) ? rd_data.key : '0;
   assign rsp_out_tag   = (state_ff == S_READ && hit_ff) ? rd_data.tag : '0;

   a_one_cycle_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result word held longer than one cycle");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("range stack pointer out of bounds");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_I || state_ff == S_SCAN_J) |->
         (i_ff >= lo_ff && i_ff <= hi_ff && j_ff >= lo_ff && j_ff <= hi_ff))
      else $error("scan index left the partition range");

   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode) |=> (rsp_valid && !rsp_sort_done))
      else $error("read word not answered on the next cycle");

endmodule

/* hdl/kpqs_ram.sv */
module kpqs_ram #(
   parameter int DATA_W = 48,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* verif/tb_key_payload_quicksort_top.sv */
`timescale 1ns / 1ps

module tb_key_payload_quicksort_top;
   import kpqs_pkg::*;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_READ    = 1'b1;
   localparam int   STALL_LIMIT  = 400000;
   localparam int   DRAIN_CYCLES = 20;
   localparam int   PHASE_ITEMS  = 215;

   typedef enum int {
      KEYS_WIDE, KEYS_CLUSTER, KEYS_EDGE, KEYS_RISING, KEYS_FALLING
   } key_mix_type;

   typedef struct {
      logic     mode;
      key_type  key;
      tag_type  tag;
      logic     last;
      addr_type read_pos;
   } word_type;

   typedef struct {
      key_type key;
      tag_type tag;
      cnt_type count;
      logic    done;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_mode = MODE_LOAD;
   logic signed [31:0] req_key = '0;
   logic [15:0] req_tag = '0;
   logic req_last = 1'b0;
   addr_type req_read_index = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_out_key;
   logic [15:0] rsp_out_tag;
   cnt_type rsp_count;
   logic rsp_sort_done;

   // shadow of the element store and batch state
   key_type key_copy [MAX_ELEMENTS];
   tag_type tag_copy [MAX_ELEMENTS];
   int      held_count = 0;
   bit      batch_sorted = 1'b0;

   answer_type answer_q[$];
   word_type   word_q[$];
   word_type   live_word;
   int      fail_cnt = 0;
   int      idle_pct = 0;
   int      quiet_cycles = 0;

   // stimulus-side view of the count, for picking in-range positions
   int      gen_count = 0;
   bit      gen_closed = 1'b0;
   int      gen_items = 0;

   key_payload_quicksort_top dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_key(req_key),
      .req_tag(req_tag),
      .req_last(req_last),
      .req_read_index(req_read_index),
      .rsp_valid(rsp_valid),
      .rsp_out_key(rsp_out_key),
      .rsp_out_tag(rsp_out_tag),
      .rsp_count(rsp_count),
      .rsp_sort_done(rsp_sort_done)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hoare partition, middle pivot, smaller side first, larger side deferred
   task automatic quicksort_copy();
      int lo, hi, i, j, dlo, dhi, depth;
      int stk_lo [STACK_DEPTH];
      int stk_hi [STACK_DEPTH];
      key_type pivot, tk;
      tag_type tt;
      lo = 0;
      hi = held_count - 1;
      depth = 0;
      forever begin
         while (hi > lo) begin
            pivot = key_copy[(lo + hi) / 2];
            i = lo;
            j = hi;
            while (i <= j) begin
               while (i < hi && key_copy[i] < pivot) i++;
               while (j > lo && pivot < key_copy[j]) j--;
               if (i <= j) begin
                  tk = key_copy[i];
                  tt = tag_copy[i];
                  key_copy[i] = key_copy[j];
                  tag_copy[i] = tag_copy[j];
                  key_copy[j] = tk;
                  tag_copy[j] = tt;
                  i++;
                  j--;
               end
            end
            if (j - lo + 1 <= hi - i + 1) begin
               dlo = i;
               dhi = hi;
               hi = j;
            end else begin
               dlo = lo;
               dhi = j;
               lo = i;
            end
            // a full stack drops the deferred range
            if (dhi > dlo && depth < STACK_DEPTH) begin
               stk_lo[depth] = dlo;
               stk_hi[depth] = dhi;
               depth++;
            end
         end
         if (depth == 0) return;
         depth--;
         lo = stk_lo[depth];
         hi = stk_hi[depth];
      end
   endtask

   task automatic sorter_mirror(input word_type w);
      answer_type a;
      if (w.mode == MODE_LOAD) begin
         if (batch_sorted) begin
            held_count = 0;
            batch_sorted = 1'b0;
         end
         if (held_count < MAX_ELEMENTS) begin
            key_copy[held_count] = w.key;
            tag_copy[held_count] = w.tag;
            held_count++;
         end
         if (w.last) begin
            quicksort_copy();
            batch_sorted = 1'b1;
            a.key = '0;
            a.tag = '0;
            a.count = cnt_type'(held_count);
            a.done = 1'b1;
            answer_q.push_back(a);
         end
      end else begin
         if (int'(w.read_pos) < held_count) begin
            a.key = key_copy[w.read_pos];
            a.tag = tag_copy[w.read_pos];
         end else begin
            a.key = '0;
            a.tag = '0;
         end
         a.count = cnt_type'(held_count);
         a.done = 1'b0;
         answer_q.push_back(a);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            sorter_mirror(live_word);
         if (!(start && busy)) begin
            if (word_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
               live_word = word_q.pop_front();
               start <= 1'b1;
               req_mode <= live_word.mode;
               req_key <= live_word.key;
               req_tag <= live_word.tag;
               req_last <= live_word.last;
               req_read_index <= live_word.read_pos;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid) begin
         if (answer_q.size() == 0) begin
            $display("%0t: word with nothing expected: key %0d tag %0d count %0d done %0b",
                     $time, rsp_out_key, rsp_out_tag, rsp_count, rsp_sort_done);
            fail_cnt++;
         end else begin
            want = answer_q.pop_front();
            if (rsp_out_key !== want.key) begin
               $display("%0t: out_key expected %0d actual %0d", $time, want.key, rsp_out_key);
               fail_cnt++;
            end
            if (rsp_out_tag !== want.tag) begin
               $display("%0t: out_tag expected %0d actual %0d", $time, want.tag, rsp_out_tag);
               fail_cnt++;
            end
            if (rsp_count !== want.count) begin
               $display("%0t: count expected %0d actual %0d", $time, want.count, rsp_count);
               fail_cnt++;
            end
            if (rsp_sort_done !== want.done) begin
               $display("%0t: sort_done expected %0b actual %0b", $time, want.done,
                        rsp_sort_done);
               fail_cnt++;
            end
         end
      end
   end

   // watchdog: cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("key_payload_quicksort_top regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_word(logic mode, key_type key, tag_type tag, logic last, addr_type pos);
      word_type w;
      w.mode = mode;
      w.key = key;
      w.tag = tag;
      w.last = last;
      w.read_pos = pos;
      word_q.push_back(w);
      gen_items++;
      if (mode == MODE_LOAD) begin
         if (gen_closed) begin
            gen_count = 0;
            gen_closed = 1'b0;
         end
         if (gen_count < MAX_ELEMENTS) gen_count++;
         if (last) gen_closed = 1'b1;
      end
   endtask

   function automatic addr_type pick_pos();
      if (gen_count > 0 && $urandom_range(7) != 0)
         return addr_type'($urandom_range(gen_count - 1));
      return addr_type'($urandom_range(MAX_ELEMENTS - 1));
   endfunction

   function automatic key_type pick_key(key_mix_type mix, int p);
      case (mix)
         KEYS_WIDE:    return key_type'($urandom);
         KEYS_CLUSTER: return key_type'($urandom_range(6)) - 3;
         KEYS_EDGE: begin
            case ($urandom_range(4))
               0:       return 32'h8000_0000;
               1:       return 32'h7fff_ffff;
               2:       return 32'h0000_0000;
               3:       return 32'hffff_ffff;
               default: return key_type'($urandom);
            endcase
         end
         KEYS_RISING:  return key_type'(p * 3 - 50);
         default:      return key_type'(1000 - p * 7);
      endcase
   endfunction

   task automatic add_read();
      add_word(MODE_READ, key_type'($urandom), tag_type'($urandom), 1'($urandom_range(1)),
               pick_pos());
   endtask

   // loads with a read slipped in now and then, closed by a last, then readback
   task automatic add_batch(int n, key_mix_type mix);
      int p;
      int reads;
      for (p = 0; p < n; p++) begin
         if ($urandom_range(15) == 0) add_read();
         add_word(MODE_LOAD, pick_key(mix, p), tag_type'($urandom), p == n - 1,
                  addr_type'($urandom));
      end
      reads = $urandom_range(1, (n < 12) ? n + 2 : 12);
      repeat (reads) add_read();
   endtask

   initial begin
      int phase_pct [4] = '{0, 75, 30, 0};
      int goal;
      int sz;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reads before any load, extremes, duplicates, unsorted read, single element
      add_word(MODE_READ, 32'h0, 16'h0, 1'b0, 10'd0);
      add_word(MODE_READ, 32'hffff_ffff, 16'hffff, 1'b1, 10'd1023);
      add_word(MODE_LOAD, 32'sd7, 16'h0001, 1'b0, 10'd1023);
      add_word(MODE_LOAD, 32'h8000_0000, 16'h0000, 1'b0, 10'd0);
      add_word(MODE_LOAD, 32'h7fff_ffff, 16'hffff, 1'b0, 10'd0);
      add_word(MODE_READ, 32'h0, 16'h0, 1'b0, 10'd1);
      add_word(MODE_LOAD, 32'sd7, 16'h0002, 1'b0, 10'd0);
      add_word(MODE_LOAD, 32'hffff_ffff, 16'h0003, 1'b0, 10'd0);
      add_word(MODE_LOAD, 32'h0, 16'h0004, 1'b1, 10'd0);
      for (int k = 0; k < 7; k++)
         add_word(MODE_READ, 32'h0, 16'h0, 1'b0, addr_type'(k));
      add_word(MODE_READ, 32'h0, 16'h0, 1'b1, 10'd1023);
      add_word(MODE_LOAD, 32'sd5, 16'haaaa, 1'b1, 10'd0);
      add_word(MODE_READ, 32'h0, 16'h0, 1'b0, 10'd0);
      add_word(MODE_READ, 32'h0, 16'h0, 1'b0, 10'd1);

      foreach (phase_pct[ph]) begin
         @(negedge clock);
         idle_pct = phase_pct[ph];
         goal = gen_items + PHASE_ITEMS;
         while (gen_items < goal) begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
            add_batch(sz, key_mix_type'($urandom_range(4)));
            if ($urandom_range(5) == 0) add_read();
         end
         while (word_q.size() != 0 || start || answer_q.size() != 0)
            @(negedge clock);
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_cnt == 0 && answer_q.size() == 0)
         $display("key_payload_quicksort_top regression: pass");
      else
         $display("key_payload_quicksort_top regression: fail");
      $finish;
   end

endmodule

/* filelist.f */
hdl/kpqs_pkg.sv
hdl/kpqs_ram.sv
hdl/key_payload_quicksort_top.sv
verif/tb_key_payload_quicksort_top.sv
